### sv/timestamp_ordered_event_sorter_macros.svh
// Assertion macros for the timestamp ordered event sorter checker.
// No dependencies; included by the checker file only.
`ifndef TIMESTAMP_ORDERED_EVENT_SORTER_MACROS_SVH
`define TIMESTAMP_ORDERED_EVENT_SORTER_MACROS_SVH

// Same-cycle implication under reset.
`define TOS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tos check failed");

// Next-cycle implication under reset.
`define TOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tos check failed");

`endif

### sv/tos_pkg.sv
// Shared types and constants for the timestamp ordered event sorter.
// No dependencies; used by the cell, the top level and the checker.
package tos_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int STAMP_W  = 64;
    localparam int EVENT_W  = 31;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_READ_FIRST = 2'd1,
        OP_READ_NEXT  = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef struct packed {
        logic insert;
        logic below_fill;
        logic at_fill;
        logic read_sel;
    } cell_ctrl_t;

endpackage

### sv/tos_cell.sv
// One storage cell of the sorted chain: holds one (stamp, event) pair.
// Depends on tos_pkg; instantiated in a row by the top level.
module tos_cell
(
    input  logic                          clk,
    input  tos_pkg::cell_ctrl_t           ctrl,
    input  logic [tos_pkg::STAMP_W-1:0]   new_stamp,
    input  logic [tos_pkg::EVENT_W-1:0]   new_event,
    input  logic [tos_pkg::STAMP_W-1:0]   prev_stamp,
    input  logic [tos_pkg::EVENT_W-1:0]   prev_event,
    input  logic                          prev_gt,
    output logic [tos_pkg::STAMP_W-1:0]   stamp,
    output logic [tos_pkg::EVENT_W-1:0]   event_num,
    output logic                          gt,
    output logic [tos_pkg::EVENT_W-1:0]   rd_data
);

    logic [tos_pkg::STAMP_W-1:0] stamp_reg;
    logic [tos_pkg::STAMP_W-1:0] stamp_next;
    logic [tos_pkg::EVENT_W-1:0] event_reg;
    logic [tos_pkg::EVENT_W-1:0] event_next;

    assign gt        = ctrl.below_fill && (stamp_reg > new_stamp);
    assign stamp     = stamp_reg;
    assign event_num = event_reg;
    assign rd_data   = ctrl.read_sel ? event_reg : '0;

    always_comb
    begin
        stamp_next = stamp_reg;
        event_next = event_reg;
        if (ctrl.insert && (ctrl.below_fill || ctrl.at_fill))
        begin
            priority if (prev_gt)
            begin
                stamp_next = prev_stamp;
                event_next = prev_event;
            end
            else if (gt || ctrl.at_fill)
            begin
                stamp_next = new_stamp;
                event_next = new_event;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        event_reg <= event_next;
    end

endmodule

### sv/timestamp_ordered_event_sorter.sv
// Timestamp ordered event sorter: a row of compare-and-shift cells kept in
// ascending stamp order, ties in arrival order. Depends on tos_pkg, tos_cell.
//
// Use:
//   Item channel (item_valid/item_ready) carries opcode, stamp, event_number.
//   Opcodes: insert, read first, read next, clear. Each transfer yields one
//   result (event_out, found, dropped) on result_valid/result_ready.
//   Insert: every cell compares its stamp against the new one in the same
//   cycle; larger entries move up one cell and the new pair drops in behind
//   the last entry that is less than or equal. A full table refuses the
//   insert and reports dropped.
//   Read: read first returns entry 0, read next the entry under the cursor;
//   a hit advances the cursor, found is low at end of list. Inserts never
//   move the cursor. Clear empties all. The result is registered.
//   Throughput: one item per cycle while no result is held by a stall.
//   Stall: a result waiting on result_ready is held in the output register;
//   a new item is taken in the same cycle the held result transfers.
//   Reset: fill count, cursor and result valid clear; cell contents are
//   left as they are and are never read before being written.
module timestamp_ordered_event_sorter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [1:0]                    opcode,
    input  logic [tos_pkg::STAMP_W-1:0]   stamp,
    input  logic [tos_pkg::EVENT_W-1:0]   event_number,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [tos_pkg::EVENT_W-1:0]   event_out,
    output logic                          found,
    output logic                          dropped
);

    localparam int N = tos_pkg::CAPACITY;

    logic [tos_pkg::IDX_W-1:0]   fill_reg;
    logic [tos_pkg::IDX_W-1:0]   fill_next;
    logic [tos_pkg::IDX_W-1:0]   cursor_reg;
    logic [tos_pkg::IDX_W-1:0]   cursor_next;
    logic                        result_valid_reg;
    logic                        result_valid_next;
    logic [tos_pkg::EVENT_W-1:0] event_out_reg;
    logic [tos_pkg::EVENT_W-1:0] event_out_next;
    logic                        found_reg;
    logic                        found_next;
    logic                        dropped_reg;
    logic                        dropped_next;

    logic                        accept;
    logic                        full;
    logic                        do_insert;
    logic                        hit;
    logic [tos_pkg::IDX_W-1:0]   read_idx;
    logic [tos_pkg::EVENT_W-1:0] rd_any;
    tos_pkg::op_t                op;

    tos_pkg::cell_ctrl_t         ctrl     [N];
    logic [tos_pkg::STAMP_W-1:0] c_stamp  [N];
    logic [tos_pkg::EVENT_W-1:0] c_event  [N];
    logic                        c_gt     [N];
    logic [tos_pkg::EVENT_W-1:0] c_rd     [N];

    assign op         = tos_pkg::op_t'(opcode);
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;
    assign full       = (fill_reg == tos_pkg::IDX_W'(N));
    assign do_insert  = accept && (op == tos_pkg::OP_INSERT) && !full;
    assign read_idx   = (op == tos_pkg::OP_READ_FIRST) ? '0 : cursor_reg;
    assign hit        = (read_idx < fill_reg);

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            assign ctrl[g].insert     = do_insert;
            assign ctrl[g].below_fill = (tos_pkg::IDX_W'(g) < fill_reg);
            assign ctrl[g].at_fill    = (tos_pkg::IDX_W'(g) == fill_reg);
            assign ctrl[g].read_sel   = (tos_pkg::IDX_W'(g) == read_idx);

            if (g == 0)
            begin : g_head
                tos_cell u_cell
                (
                    .clk        (clk),
                    .ctrl       (ctrl[g]),
                    .new_stamp  (stamp),
                    .new_event  (event_number),
                    .prev_stamp (stamp),
                    .prev_event (event_number),
                    .prev_gt    (1'b0),
                    .stamp      (c_stamp[g]),
                    .event_num  (c_event[g]),
                    .gt         (c_gt[g]),
                    .rd_data    (c_rd[g])
                );
            end
            else
            begin : g_body
                tos_cell u_cell
                (
                    .clk        (clk),
                    .ctrl       (ctrl[g]),
                    .new_stamp  (stamp),
                    .new_event  (event_number),
                    .prev_stamp (c_stamp[g-1]),
                    .prev_event (c_event[g-1]),
                    .prev_gt    (c_gt[g-1]),
                    .stamp      (c_stamp[g]),
                    .event_num  (c_event[g]),
                    .gt         (c_gt[g]),
                    .rd_data    (c_rd[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < N; i++)
        begin
            rd_any = rd_any | c_rd[i];
        end
    end

    always_comb
    begin
        fill_next         = fill_reg;
        cursor_next       = cursor_reg;
        event_out_next    = event_out_reg;
        found_next        = found_reg;
        dropped_next      = dropped_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (accept)
        begin
            result_valid_next = 1'b1;
            event_out_next    = '0;
            found_next        = 1'b0;
            dropped_next      = 1'b0;
            unique case (op)
                tos_pkg::OP_INSERT:
                begin
                    dropped_next = full;
                    if (!full)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
                tos_pkg::OP_READ_FIRST,
                tos_pkg::OP_READ_NEXT:
                begin
                    cursor_next = read_idx;
                    if (hit)
                    begin
                        event_out_next = rd_any;
                        found_next     = 1'b1;
                        cursor_next    = read_idx + 1'b1;
                    end
                end
                tos_pkg::OP_CLEAR:
                begin
                    fill_next   = '0;
                    cursor_next = '0;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            cursor_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg         <= fill_next;
            cursor_reg       <= cursor_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_out_reg <= event_out_next;
        found_reg     <= found_next;
        dropped_reg   <= dropped_next;
    end

    assign result_valid = result_valid_reg;
    assign event_out    = event_out_reg;
    assign found        = found_reg;
    assign dropped      = dropped_reg;

endmodule

### sv/tos_checker.sv
// Port-level checks for the timestamp ordered event sorter, bound to the top.
// Depends on tos_pkg and timestamp_ordered_event_sorter_macros.svh.
`include "timestamp_ordered_event_sorter_macros.svh"

module tos_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic [1:0]                    opcode,
    input logic [tos_pkg::STAMP_W-1:0]   stamp,
    input logic [tos_pkg::EVENT_W-1:0]   event_number,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [tos_pkg::EVENT_W-1:0]   event_out,
    input logic                          found,
    input logic                          dropped
);

    `TOS_ASSERT_NOW(a_flags_exclusive, result_valid, !(found && dropped))
    `TOS_ASSERT_NOW(a_miss_zero, result_valid && !found, event_out == '0)
    `TOS_ASSERT_NEXT(a_hold_stalled, result_valid && !result_ready,
        result_valid && $stable(event_out) && $stable(found) && $stable(dropped))
    `TOS_ASSERT_NEXT(a_insert_no_found,
        item_valid && item_ready && (opcode == tos_pkg::OP_INSERT),
        result_valid && !found)
    `TOS_ASSERT_NEXT(a_other_no_drop,
        item_valid && item_ready && (opcode != tos_pkg::OP_INSERT),
        result_valid && !dropped)

endmodule

bind timestamp_ordered_event_sorter tos_checker u_tos_checker (.*);
